// ----- rtl/core/frame_rate_meter_ema_defines.svh -----
// Assertion macros shared by the frame rate meter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FRAME_RATE_METER_EMA_DEFINES_SVH
`define FRAME_RATE_METER_EMA_DEFINES_SVH
`ifndef ASSERT_OFF
// Implication in the same cycle, checked at every edge out of reset
`define FRM_ASSERT(label, clk, rstn, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cons)) \
        else $error("frame rate meter check failed");
// Implication in the next cycle
`define FRM_ASSERT_NEXT(label, clk, rstn, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
        else $error("frame rate meter check failed");
`else
`define FRM_ASSERT(label, clk, rstn, trig, cons)
`define FRM_ASSERT_NEXT(label, clk, rstn, trig, cons)
`endif
`endif

// ----- rtl/core/frm_ema_pkg.sv -----
// Package for the frame rate meter: sequencer states, register indexes,
// reset values and fixed widths. No dependencies.
`timescale 1ns / 1ps

package frm_ema_pkg;

    // Field and datapath widths
    localparam int unsigned TICK_W  = 24;
    localparam int unsigned WGT_W   = 9;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned RATE_W  = 32;
    localparam int unsigned NUM_W   = 56;
    localparam int unsigned CNT_W   = 6;

    // Divider step counts for the two quotients
    localparam logic [CNT_W-1:0] DIV_STEPS_INST = 6'd32;
    localparam logic [CNT_W-1:0] DIV_STEPS_AVG  = 6'd56;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_TICKS_PER_SEC = 8'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_TICKS  = 8'd1;
    localparam logic [IDX_W-1:0] REG_EMA_WEIGHT    = 8'd2;
    localparam logic [IDX_W-1:0] REG_EMA_START     = 8'd3;

    // Register reset values
    localparam logic [TICK_W-1:0] RST_TICKS_PER_SEC = 24'd1000000;
    localparam logic [TICK_W-1:0] RST_WINDOW_TICKS  = 24'd250000;
    localparam logic [WGT_W-1:0]  RST_EMA_WEIGHT    = 9'd64;
    localparam logic [TICK_W-1:0] RST_EMA_START     = 24'd60;

    localparam logic [WGT_W-1:0]  WGT_FULL = 9'd256;
    localparam logic [TICK_W-1:0] SAT24    = 24'hFFFFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_INST,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_MIX,
        ST_CHECK,
        ST_MUL_AVG,
        ST_LOAD_AVG,
        ST_DIV_AVG,
        ST_REPORT
    } state_t;

endpackage

// ----- rtl/core/frame_rate_meter_ema.sv -----
// Frame rate meter with exponential smoothing. Each request on s_ carries one
// frame duration in ticks; a report on m_ is the rounded mean of the window
// rate and the smoothed rate, in frames per second. One shared restoring
// divider (one quotient bit per cycle) and one 32x24 multiplier do all the
// arithmetic under a small sequencer, and s_tready is low while an item is in
// work. A request with a nonzero duration runs the rate division and then the
// ema multiply and mix steps before the window check; a zero duration goes
// straight to the check. A request that closes a window adds the multiply
// and division for the window rate, plus any wait for m_tready if the previous
// report has not been taken. A finished report sits in the output register
// while the next request is taken. cfg_ready is always high; writes are meant
// for idle periods, and a write to ema_start also reloads the smoothed rate.
// Depends on frm_ema_pkg and frame_rate_meter_ema_defines.svh.
`timescale 1ns / 1ps
`include "frame_rate_meter_ema_defines.svh"

module frame_rate_meter_ema
    import frm_ema_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0] cfg_data,
    // frame durations
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TICK_W-1:0] s_tdata,   // [23:0] frame_ticks
    // rate reports
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [TICK_W-1:0] m_tdata    // [23:0] rate_report
);

    // Sequencer
    state_t state_reg, state_next;

    // Configuration registers
    logic [TICK_W-1:0] tps_reg;
    logic [TICK_W-1:0] win_reg;
    logic [WGT_W-1:0]  wgt_reg;

    // Meter state
    logic [RATE_W-1:0] wt_reg;
    logic [TICK_W-1:0] fc_reg;
    logic [RATE_W-1:0] sm_reg;

    // Shared divider: numerator/quotient shifter, partial remainder, divisor
    logic [NUM_W-1:0]  nq_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Multiplier product and ema accumulator
    logic [NUM_W-1:0]  prod_reg;
    logic [40:0]       acc_reg;

    // Output register
    logic              m_tvalid_reg;
    logic [TICK_W-1:0] m_tdata_reg;

    // Decoded controls
    logic s_tready_c;
    logic div_step;
    logic in_acc;
    logic out_free;
    logic cfg_acc;

    logic [WGT_W-1:0]  w_eff;
    logic [TICK_W-1:0] win_eff;
    logic [32:0]       wt_sum;
    logic [RATE_W-1:0] wt_acc;

    logic [32:0]       rem_sh;
    logic [33:0]       rem_sub;
    logic              q_bit;
    logic [RATE_W-1:0] rem_new;

    logic [RATE_W-1:0] mul_a;
    logic [TICK_W-1:0] mul_b;
    logic [NUM_W-1:0]  mul_p;

    logic [40:0]       mix_sum;
    logic [56:0]       rpt_sum;
    logic [TICK_W-1:0] rpt_val;
    logic              win_hit;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = s_tready_c;
    assign in_acc    = s_tvalid && s_tready_c;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Effective weight and window length
    assign w_eff   = (wgt_reg > WGT_FULL) ? WGT_FULL : wgt_reg;
    assign win_eff = (win_reg == '0) ? TICK_W'(1) : win_reg;

    // Window time accumulate, saturating at 32 bits
    assign wt_sum = {1'b0, wt_reg} + {9'b0, s_tdata};
    assign wt_acc = wt_sum[32] ? '1 : wt_sum[RATE_W-1:0];
    assign win_hit = (wt_reg >= {8'b0, win_eff});

    // Restoring divider step
    assign rem_sh  = {rem_reg, nq_reg[NUM_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, div_reg};
    assign q_bit   = !rem_sub[33];
    assign rem_new = q_bit ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];

    // Shared multiplier operand select
    always_comb begin
        mul_a = sm_reg;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_OLD: begin
                mul_a = sm_reg;
                mul_b = {15'b0, WGT_FULL - w_eff};
            end
            ST_MUL_NEW: begin
                mul_a = nq_reg[RATE_W-1:0];
                mul_b = {15'b0, w_eff};
            end
            ST_MUL_AVG: begin
                mul_a = {8'b0, fc_reg};
                mul_b = tps_reg;
            end
            default: begin
                mul_a = sm_reg;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Ema mix and report rounding
    assign mix_sum = acc_reg + prod_reg[40:0];
    assign rpt_sum = {1'b0, nq_reg} + {25'b0, sm_reg} + 57'd256;
    assign rpt_val = (|rpt_sum[56:33]) ? SAT24 : rpt_sum[32:9];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_tdata != '0) ? ST_DIV_INST : ST_CHECK;
                end
            end
            ST_DIV_INST: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD:  state_next = ST_MUL_NEW;
            ST_MUL_NEW:  state_next = ST_MIX;
            ST_MIX:      state_next = ST_CHECK;
            ST_CHECK:    state_next = win_hit ? ST_MUL_AVG : ST_IDLE;
            ST_MUL_AVG:  state_next = ST_LOAD_AVG;
            ST_LOAD_AVG: state_next = ST_DIV_AVG;
            ST_DIV_AVG: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready_c = 1'b0;
        div_step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:     s_tready_c = 1'b1;
            ST_DIV_INST: div_step   = 1'b1;
            ST_DIV_AVG:  div_step   = 1'b1;
            default: begin
                s_tready_c = 1'b0;
                div_step   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg      <= RST_TICKS_PER_SEC;
            win_reg      <= RST_WINDOW_TICKS;
            wgt_reg      <= RST_EMA_WEIGHT;
            wt_reg       <= '0;
            fc_reg       <= '0;
            sm_reg       <= {8'b0, RST_EMA_START} << FRAC_W;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output register: load a report, else drain
            if (state_reg == ST_REPORT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // new request: accumulate, count, load divider for the rate
            if (in_acc) begin
                wt_reg  <= wt_acc;
                if (fc_reg != SAT24) begin
                    fc_reg <= fc_reg + TICK_W'(1);
                end
                nq_reg  <= {tps_reg, {FRAC_W{1'b0}}, {TICK_W{1'b0}}};
                rem_reg <= '0;
                div_reg <= {8'b0, s_tdata};
                cnt_reg <= DIV_STEPS_INST;
            end

            // one quotient bit a cycle
            if (div_step) begin
                rem_reg <= rem_new;
                nq_reg  <= {nq_reg[NUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            // ema terms and window product
            if (state_reg == ST_MUL_OLD || state_reg == ST_MUL_NEW ||
                state_reg == ST_MUL_AVG) begin
                prod_reg <= mul_p;
            end
            if (state_reg == ST_MUL_NEW) begin
                acc_reg <= prod_reg[40:0];
            end
            // a write of ema_start takes precedence over the mix
            if (state_reg == ST_MIX && !(cfg_acc && cfg_index == REG_EMA_START)) begin
                sm_reg <= mix_sum[39:8];
            end

            // window rate numerator into the divider
            if (state_reg == ST_LOAD_AVG) begin
                nq_reg  <= {prod_reg[47:0], {FRAC_W{1'b0}}};
                rem_reg <= '0;
                div_reg <= wt_reg;
                cnt_reg <= DIV_STEPS_AVG;
            end

            // report and restart the window
            if (state_reg == ST_REPORT && out_free) begin
                m_tdata_reg  <= rpt_val;
                wt_reg       <= wt_reg - {8'b0, win_eff};
                fc_reg       <= '0;
            end

            // register writes, unknown index ignored
            if (cfg_acc) begin
                unique case (cfg_index)
                    REG_TICKS_PER_SEC: tps_reg <= cfg_data;
                    REG_WINDOW_TICKS:  win_reg <= cfg_data;
                    REG_EMA_WEIGHT:    wgt_reg <= cfg_data[WGT_W-1:0];
                    REG_EMA_START:     sm_reg  <= {cfg_data, {FRAC_W{1'b0}}};
                    default: ;
                endcase
            end
        end
    end

    // Checks
    `FRM_ASSERT(a_rem_below_div, aclk, aresetn, div_step, rem_reg < div_reg)
    `FRM_ASSERT(a_div_cnt_live, aclk, aresetn, div_step, cnt_reg != '0)
    `FRM_ASSERT_NEXT(a_accept_busy, aclk, aresetn, in_acc, !s_tready)
    `FRM_ASSERT_NEXT(a_report_clears, aclk, aresetn,
        (state_reg == ST_REPORT) && out_free, (fc_reg == '0) && m_tvalid)
    `FRM_ASSERT(a_report_window, aclk, aresetn, state_reg == ST_MUL_AVG,
        wt_reg >= {8'b0, win_eff})

endmodule
